// ----- sv/msji_pkg.sv -----
// shared types, codes and saturation helpers for the joint integrator
package msji_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned PROD_W = 2 * WORD_W;

	typedef enum logic [1:0] {
		OP_SPRING = 2'd0,
		OP_STEP   = 2'd1,
		OP_NUDGE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_TIME_STEP = 3'd0,
		REG_INV_MASS  = 3'd1,
		REG_GRAVITY   = 3'd2,
		REG_RADIUS    = 3'd3,
		REG_LEFT      = 3'd4,
		REG_RIGHT     = 3'd5,
		REG_BOTTOM    = 3'd6,
		REG_TOP       = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SPX_MUL,
		ST_SPX_DIV,
		ST_SPY_MUL,
		ST_SPY_DIV,
		ST_CLAMP_X,
		ST_CLAMP_Y,
		ST_REACT,
		ST_AX,
		ST_ADTX,
		ST_HX,
		ST_MVX,
		ST_AY,
		ST_ADTY,
		ST_HY,
		ST_MVY,
		ST_NUDGE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] spring_force;
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic [30:0]        spring_length;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               hit_side;
		logic               hit_floor;
	} out_item_t;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

	// clamp a 34 bit sum to 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = SAT_MAX;
		end else if (v < -34'sh0_8000_0000) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat34(34'(a) + 34'(b));
	endfunction

	function automatic logic signed [31:0] sat_add3(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] c);
		return sat34(34'(a) + 34'(b) + 34'(c));
	endfunction

	function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
		return sat34(-34'(a));
	endfunction

	// sign and magnitude to saturated 32 bit value
	function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
		logic signed [31:0] r;
		if (!neg) begin
			r = (mag > 64'h7FFF_FFFF) ? SAT_MAX : signed'(mag[31:0]);
		end else begin
			r = (mag > 64'h8000_0000) ? SAT_MIN : signed'(32'(-mag[31:0]));
		end
		return r;
	endfunction

	// halve with truncation toward zero
	function automatic logic signed [31:0] halve(input logic signed [31:0] m);
		logic signed [32:0] e;
		e = 33'(m) + 33'({32'd0, m[31]});
		return e[32:1];
	endfunction

endpackage

// ----- sv/mass_spring_joint_integrator.sv -----
// mass-spring particle integrator: sequencer, state and serial arithmetic
//
// channel | dir | handshake        | beat
// in      | in  | in_valid/stall   | in_item_t: operation, spring, deltas, length
// out     | out | out_valid/stall  | out_item_t: position, velocity, hit flags
// cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// one item at a time; a spring beat runs two serial multiplies and two serial
// divides, a step beat runs eight serial multiplies, and a nudge beat uses
// neither the multiplier nor the divider.
// arst_n clears the particle state and loads the register defaults.
// in_stall is high whenever an item is in work; a finished beat waits in the
// output register while out_stall is high.
module mass_spring_joint_integrator #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  msji_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output msji_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import msji_pkg::*;

	state_t state_q, state_d;

	logic [16:0]        time_step_q;
	logic [30:0]        inv_mass_q;
	logic signed [31:0] gravity_q;
	logic [30:0]        radius_q;
	logic signed [31:0] left_q, right_q, bottom_q, top_q;

	logic signed [31:0] px_q, py_q, vx_q, vy_q, fsx_q, fsy_q, fr_q;
	logic signed [31:0] t_q, tmp_q, half_q;
	logic               side_q, flr_q, wait_q;
	in_item_t           item_q;

	logic               out_valid_q;
	out_item_t          out_q;

	logic               mul_start, mul_busy, mul_done, mul_neg;
	logic signed [31:0] mul_a, mul_b;
	logic [63:0]        mul_mag;
	logic               div_start, div_busy, div_done;
	logic [63:0]        div_quo;

	logic signed [31:0] mulq_res, div_res;
	logic               unit_done;
	logic               in_accept, out_free;

	logic signed [33:0] r34, px34, py34;
	logic               hit_l, hit_r, hit_b, hit_t;
	logic signed [31:0] px_clamp, py_clamp, react_sum;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// serial units
	msji_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .mag(mul_mag), .neg(mul_neg)
	);

	msji_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mul_mag),
		.divisor(item_q.spring_length), .busy(div_busy), .done(div_done),
		.quotient(div_quo)
	);

	// scaled product and spring quotient
	assign mulq_res = sat_mag(mul_mag >> FRAC_BITS, mul_neg);
	assign div_res  = sat_mag(div_quo, mul_neg);

	// boundary tests
	assign r34      = 34'(signed'({1'b0, radius_q}));
	assign px34     = 34'(px_q);
	assign py34     = 34'(py_q);
	assign hit_l    = (px34 - r34) <= 34'(left_q);
	assign hit_r    = (px34 + r34) >= 34'(right_q);
	assign hit_b    = (py34 - r34) <= 34'(bottom_q);
	assign hit_t    = (py34 + r34) >= 34'(top_q);
	assign px_clamp = hit_l ? sat34(34'(left_q) + r34) : sat34(34'(right_q) - r34);
	assign py_clamp = hit_b ? sat34(34'(bottom_q) + r34) : sat34(34'(top_q) - r34);
	assign react_sum = sat_add(fsy_q, gravity_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (item_q.operation)
					OP_SPRING: state_d = (item_q.spring_length == '0) ? ST_IDLE : ST_SPX_MUL;
					OP_STEP:   state_d = ST_CLAMP_X;
					OP_NUDGE:  state_d = ST_NUDGE;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_SPX_MUL: if (wait_q && mul_done) state_d = ST_SPX_DIV;
			ST_SPX_DIV: if (wait_q && div_done) state_d = ST_SPY_MUL;
			ST_SPY_MUL: if (wait_q && mul_done) state_d = ST_SPY_DIV;
			ST_SPY_DIV: if (wait_q && div_done) state_d = ST_IDLE;
			ST_CLAMP_X: state_d = ST_CLAMP_Y;
			ST_CLAMP_Y: state_d = ST_REACT;
			ST_REACT:   state_d = ST_AX;
			ST_AX:      if (wait_q && mul_done) state_d = ST_ADTX;
			ST_ADTX:    if (wait_q && mul_done) state_d = ST_HX;
			ST_HX:      if (wait_q && mul_done) state_d = ST_MVX;
			ST_MVX:     if (wait_q && mul_done) state_d = ST_AY;
			ST_AY:      if (wait_q && mul_done) state_d = ST_ADTY;
			ST_ADTY:    if (wait_q && mul_done) state_d = ST_HY;
			ST_HY:      if (wait_q && mul_done) state_d = ST_MVY;
			ST_MVY:     if (wait_q && mul_done) state_d = ST_OUT;
			ST_NUDGE:   state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit starts and operand selection
	always_comb begin
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = fsx_q;
		mul_b     = signed'({15'd0, time_step_q});
		unit_done = 1'b0;
		case (state_q)
			ST_SPX_MUL: begin
				mul_start = !wait_q;
				mul_a     = item_q.spring_force;
				mul_b     = item_q.delta_x;
				unit_done = mul_done;
			end
			ST_SPY_MUL: begin
				mul_start = !wait_q;
				mul_a     = item_q.spring_force;
				mul_b     = item_q.delta_y;
				unit_done = mul_done;
			end
			ST_SPX_DIV, ST_SPY_DIV: begin
				div_start = !wait_q;
				unit_done = div_done;
			end
			ST_AX: begin
				mul_start = !wait_q;
				mul_a     = fsx_q;
				mul_b     = signed'({1'b0, inv_mass_q});
				unit_done = mul_done;
			end
			ST_AY: begin
				mul_start = !wait_q;
				mul_a     = t_q;
				mul_b     = signed'({1'b0, inv_mass_q});
				unit_done = mul_done;
			end
			ST_ADTX, ST_HX, ST_ADTY, ST_HY: begin
				mul_start = !wait_q;
				mul_a     = tmp_q;
				unit_done = mul_done;
			end
			ST_MVX: begin
				mul_start = !wait_q;
				mul_a     = vx_q;
				unit_done = mul_done;
			end
			ST_MVY: begin
				mul_start = !wait_q;
				mul_a     = vy_q;
				unit_done = mul_done;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// state register and unit wait flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				wait_q <= 1'b1;
			end else if (wait_q && unit_done) begin
				wait_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 17'd1092;
			inv_mass_q  <= 31'd65536;
			gravity_q   <= '0;
			radius_q    <= '0;
			left_q      <= -32'sd6553600;
			right_q     <= 32'sd6553600;
			bottom_q    <= -32'sd6553600;
			top_q       <= 32'sd6553600;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TIME_STEP: time_step_q <= cfg_data[16:0];
				REG_INV_MASS:  inv_mass_q  <= cfg_data[30:0];
				REG_GRAVITY:   gravity_q   <= cfg_data;
				REG_RADIUS:    radius_q    <= cfg_data[30:0];
				REG_LEFT:      left_q      <= cfg_data;
				REG_RIGHT:     right_q     <= cfg_data;
				REG_BOTTOM:    bottom_q    <= cfg_data;
				REG_TOP:       top_q       <= cfg_data;
				default:       time_step_q <= time_step_q;
			endcase
		end
	end

	// particle state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q   <= '0;
			py_q   <= '0;
			vx_q   <= '0;
			vy_q   <= '0;
			fsx_q  <= '0;
			fsy_q  <= '0;
			fr_q   <= '0;
			side_q <= 1'b0;
			flr_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_SPX_DIV: if (wait_q && div_done) fsx_q <= sat_add(fsx_q, div_res);
				ST_SPY_DIV: if (wait_q && div_done) fsy_q <= sat_add(fsy_q, div_res);
				ST_CLAMP_X: begin
					side_q <= hit_l || hit_r;
					if (hit_l || hit_r) begin
						px_q  <= px_clamp;
						fsx_q <= sat_neg(fsx_q);
					end
				end
				ST_CLAMP_Y: begin
					flr_q <= hit_b || hit_t;
					if (hit_b || hit_t) py_q <= py_clamp;
				end
				ST_REACT: begin
					if (flr_q) fr_q <= react_sum[31] ? sat_neg(react_sum) : '0;
				end
				ST_ADTX: if (wait_q && mul_done) vx_q <= sat_add(vx_q, mulq_res);
				ST_MVX:  if (wait_q && mul_done) px_q <= sat_add3(px_q, mulq_res, half_q);
				ST_ADTY: if (wait_q && mul_done) vy_q <= sat_add(vy_q, mulq_res);
				ST_MVY: begin
					if (wait_q && mul_done) begin
						py_q  <= sat_add3(py_q, mulq_res, half_q);
						fsx_q <= '0;
						fsy_q <= '0;
					end
				end
				ST_NUDGE: begin
					px_q   <= sat_add(px_q, item_q.delta_x);
					py_q   <= sat_add(py_q, item_q.delta_y);
					side_q <= 1'b0;
					flr_q  <= 1'b0;
				end
				default: begin
					side_q <= side_q;
				end
			endcase
		end
	end

	// item capture and step temporaries
	always_ff @(posedge clk) begin
		if (in_accept) item_q <= in_data;
		case (state_q)
			ST_AX: begin
				if (!wait_q) t_q <= sat_add3(fsy_q, gravity_q, fr_q);
				if (wait_q && mul_done) tmp_q <= mulq_res;
			end
			ST_AY, ST_ADTX, ST_ADTY: if (wait_q && mul_done) tmp_q <= mulq_res;
			ST_HX, ST_HY: if (wait_q && mul_done) half_q <= halve(mulq_res);
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q.pos_x     <= px_q;
			out_q.pos_y     <= py_q;
			out_q.vel_x     <= vx_q;
			out_q.vel_y     <= vy_q;
			out_q.hit_side  <= side_q;
			out_q.hit_floor <= flr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the two serial units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy))
		else $error("multiplier and divider busy together");

	// an accepted beat always goes to dispatch
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_DISPATCH)
		else $error("accepted beat not dispatched");

	// a result leaving the sequencer lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> out_valid_q)
		else $error("result not loaded");

	// a unit is only started when none is in flight
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_start || div_start) |-> (!wait_q && !mul_busy && !div_busy))
		else $error("unit started while busy");

endmodule

// ----- sv/msji_mul.sv -----
// bit-serial sign and magnitude multiplier, one multiplier bit per cycle
module msji_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               busy,
	output logic               done,
	output logic [63:0]        mag,
	output logic               neg
);
	import msji_pkg::*;

	logic [31:0] a_q;
	logic [63:0] p_q;
	logic        neg_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] sum;

	// partial sum of the upper half and the multiplicand
	assign sum = {1'b0, p_q[63:32]} + (p_q[0] ? {1'b0, a_q} : 33'd0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// shift-add datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a[31] ? 32'(-a) : a;
			p_q   <= {32'd0, (b[31] ? 32'(-b) : b)};
			neg_q <= a[31] ^ b[31];
		end else if (busy_q) begin
			p_q <= {sum, p_q[31:1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign mag  = p_q;
	assign neg  = neg_q;

endmodule

// ----- sv/msji_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module msji_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [30:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [63:0] quotient
);
	import msji_pkg::*;

	logic [63:0] n_q;
	logic [30:0] rem_q;
	logic [30:0] d_q;
	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [31:0] r2;
	logic        ge;
	logic [31:0] rnew;

	// trial subtract
	assign r2   = {rem_q, n_q[63]};
	assign ge   = r2 >= {1'b0, d_q};
	assign rnew = ge ? (r2 - {1'b0, d_q}) : r2;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= rnew[30:0];
			n_q   <= {n_q[62:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = n_q;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the mass-spring joint integrator
module testbench;
	import msji_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	mass_spring_joint_integrator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int FRAC = 16;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;

	// predicted particle state and registers
	longint dt, inv_m, grav, rad, lb, rb, bb, tb;
	longint px, py, vx, vy, fx, fy, frc;

	out_item_t expected_beats[$];
	int        errors;
	int        send_idle_pct;
	int        stall_pct;

	function automatic longint clip(input longint v);
		if (v > MAXV) return MAXV;
		if (v < MINV) return MINV;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip((a * b) / (64'sd1 <<< FRAC));
	endfunction

	task automatic reset_model();
		dt = 1092; inv_m = 65536; grav = 0; rad = 0;
		lb = -6553600; rb = 6553600; bb = -6553600; tb = 6553600;
		px = 0; py = 0; vx = 0; vy = 0; fx = 0; fy = 0; frc = 0;
	endtask

	// advance the predicted particle by one accepted beat
	task automatic predict_beat(input in_item_t it);
		longint f, dx, dy, len, ax, ay, adt, half, s;
		logic side, flr;
		out_item_t o;
		f = longint'(it.spring_force);
		dx = longint'(it.delta_x);
		dy = longint'(it.delta_y);
		len = longint'({1'b0, it.spring_length});
		side = 1'b0; flr = 1'b0;
		case (op_t'(it.operation))
			OP_SPRING: begin
				if (len != 0) begin
					fx = clip(fx + clip((f * dx) / len));
					fy = clip(fy + clip((f * dy) / len));
				end
				return;
			end
			OP_STEP: begin
				if (px - rad <= lb) begin
					px = clip(lb + rad); side = 1'b1;
				end else if (px + rad >= rb) begin
					px = clip(rb - rad); side = 1'b1;
				end
				if (side) fx = clip(-fx);
				if (py - rad <= bb) begin
					py = clip(bb + rad); flr = 1'b1;
				end else if (py + rad >= tb) begin
					py = clip(tb - rad); flr = 1'b1;
				end
				if (flr) begin
					s = clip(fy + grav);
					frc = (s < 0) ? clip(-s) : 0;
				end
				ax = qmul(fx, inv_m);
				ay = qmul(clip(fy + grav + frc), inv_m);
				adt = qmul(ax, dt);
				vx = clip(vx + adt);
				half = qmul(adt, dt) / 2;
				px = clip(px + qmul(vx, dt) + half);
				adt = qmul(ay, dt);
				vy = clip(vy + adt);
				half = qmul(adt, dt) / 2;
				py = clip(py + qmul(vy, dt) + half);
				fx = 0; fy = 0;
			end
			OP_NUDGE: begin
				px = clip(px + dx);
				py = clip(py + dy);
			end
			default: return;
		endcase
		o.pos_x = px[31:0]; o.pos_y = py[31:0];
		o.vel_x = vx[31:0]; o.vel_y = vy[31:0];
		o.hit_side = side; o.hit_floor = flr;
		expected_beats = {expected_beats, o};
	endtask

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#40000000;
		$display("testbench: done, errors");
		$finish;
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				report("unexpected beat", 0, 0);
			end else begin
				w = expected_beats.pop_front();
				if (out_data.pos_x !== w.pos_x) report("pos_x", out_data.pos_x, w.pos_x);
				if (out_data.pos_y !== w.pos_y) report("pos_y", out_data.pos_y, w.pos_y);
				if (out_data.vel_x !== w.vel_x) report("vel_x", out_data.vel_x, w.vel_x);
				if (out_data.vel_y !== w.vel_y) report("vel_y", out_data.vel_y, w.vel_y);
				if (out_data.hit_side !== w.hit_side)
					report("hit_side", out_data.hit_side, w.hit_side);
				if (out_data.hit_floor !== w.hit_floor)
					report("hit_floor", out_data.hit_floor, w.hit_floor);
			end
		end
	end

	// send one beat, holding it until accepted; valid stays up until the next gap
	task automatic send_beat(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_beat(it);
	endtask

	// wait until idle; a spring beat can still be in work with nothing expected
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIME_STEP: dt = longint'(v[16:0]);
			REG_INV_MASS:  inv_m = longint'(v[30:0]);
			REG_GRAVITY:   grav = longint'(signed'(v));
			REG_RADIUS:    rad = longint'(v[30:0]);
			REG_LEFT:      lb = longint'(signed'(v));
			REG_RIGHT:     rb = longint'(signed'(v));
			REG_BOTTOM:    bb = longint'(signed'(v));
			REG_TOP:       tb = longint'(signed'(v));
			default:       tb = tb;
		endcase
		@(posedge clk);
	endtask

	function automatic in_item_t make_beat(input op_t op, input logic [31:0] f,
			input logic [31:0] dx, input logic [31:0] dy, input logic [30:0] len);
		in_item_t it;
		it.operation = op; it.spring_force = f;
		it.delta_x = dx; it.delta_y = dy; it.spring_length = len;
		return it;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(131072)) - 65536);
			3: return 32'(signed'($urandom_range(20000000)) - 10000000);
			default: return $urandom;
		endcase
	endfunction

	// extremes, every operation and each corner case
	task automatic test_directed();
		send_beat(make_beat(OP_SPRING, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 31'd0));
		send_beat(make_beat(OP_SPRING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1));
		send_beat(make_beat(OP_SPRING, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			31'h7FFF_FFFF));
		send_beat(make_beat(OP_STEP, 0, 0, 0, 0));
		send_beat(make_beat(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			31'h7FFF_FFFF));
		send_beat(make_beat(OP_NUDGE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_beat(make_beat(OP_NUDGE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_beat(make_beat(OP_STEP, 0, 0, 0, 0));
		send_beat(make_beat(OP_NUDGE, 0, 32'h8000_0000, 32'h8000_0000, 0));
		send_beat(make_beat(OP_NUDGE, 0, 32'h8000_0000, 32'h8000_0000, 0));
		send_beat(make_beat(OP_SPRING, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 31'd1));
		send_beat(make_beat(OP_STEP, 0, 0, 0, 0));
		send_beat(make_beat(OP_NUDGE, 0, 32'h0010_0000, 32'hFFF0_0000, 0));
		send_beat(make_beat(OP_STEP, 0, 0, 0, 0));
		drain();
	endtask

	// mostly spring runs closed by a step, with nudges and unused codes mixed in
	task automatic test_random(input int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it = make_beat(OP_SPRING, rand_word(), rand_word(), rand_word(),
				($urandom_range(9) == 0) ? 31'd0 : 31'(rand_word()));
			case ($urandom_range(9))
				0, 1, 2: it.operation = OP_STEP;
				3:       it.operation = OP_NUDGE;
				4:       it.operation = ($urandom_range(3) == 0) ? OP_NONE : OP_NUDGE;
				default: it.operation = OP_SPRING;
			endcase
			if (it.operation != OP_SPRING) it.spring_length = 31'($urandom);
			send_beat(it);
		end
		drain();
	endtask

	// register settings including extremes
	task automatic test_registers(input int phase);
		case (phase)
			0: begin
				write_reg(REG_TIME_STEP, 32'h0001_0000);
				write_reg(REG_INV_MASS, 32'h7FFF_FFFF);
				write_reg(REG_GRAVITY, 32'h8000_0000);
				write_reg(REG_RADIUS, 32'h0000_0000);
				write_reg(REG_LEFT, 32'h8000_0000);
				write_reg(REG_RIGHT, 32'h7FFF_FFFF);
				write_reg(REG_BOTTOM, 32'h8000_0000);
				write_reg(REG_TOP, 32'h7FFF_FFFF);
			end
			1: begin
				write_reg(REG_TIME_STEP, 32'h0000_0000);
				write_reg(REG_INV_MASS, 32'h0000_0000);
				write_reg(REG_GRAVITY, 32'h7FFF_FFFF);
				write_reg(REG_RADIUS, 32'h7FFF_FFFF);
				write_reg(REG_LEFT, 32'h0000_0000);
				write_reg(REG_RIGHT, 32'h0000_0000);
				write_reg(REG_BOTTOM, 32'h7FFF_FFFF);
				write_reg(REG_TOP, 32'h8000_0000);
			end
			default: begin
				write_reg(REG_TIME_STEP, 32'($urandom_range(65536)));
				write_reg(REG_INV_MASS, $urandom & 32'h7FFF_FFFF);
				write_reg(REG_GRAVITY, rand_word());
				write_reg(REG_RADIUS, $urandom_range(300000));
				write_reg(REG_LEFT, -32'sd1 * 32'($urandom_range(20000000)));
				write_reg(REG_RIGHT, 32'($urandom_range(20000000)));
				write_reg(REG_BOTTOM, -32'sd1 * 32'($urandom_range(20000000)));
				write_reg(REG_TOP, 32'($urandom_range(20000000)));
			end
		endcase
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(100);
		send_idle_pct = 76;
		test_registers(0);
		test_directed();
		test_random(80);
		send_idle_pct = 0;
		stall_pct = 76;
		test_registers(1);
		test_random(60);
		send_idle_pct = 19;
		stall_pct = 19;
		test_registers(2);
		test_random(90);
		send_idle_pct = 0;
		stall_pct = 0;
		test_registers(2);
		test_random(90);

		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
